// File: design/aards_pkg.sv
// Shared types, constants and helpers for the area-average RGB downscaler.
// Used by the interfaces, the top module and the divider; depends on nothing.
`default_nettype none

package aards_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 2048;
	localparam int MAX_DIM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;

	localparam int CFG_W = 12;
	localparam int PIX_W = 8;
	localparam int NUM_CH = 3;
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int DIM_W = $clog2(MAX_DIM) + 1;
	localparam int SUM_W = $clog2(MAX_DIM * 255 + 1);
	localparam int LINE_W = NUM_CH * SUM_W;

	localparam logic [CFG_W-1:0] RST_SRC_W = CFG_W'(640);
	localparam logic [CFG_W-1:0] RST_SRC_H = CFG_W'(480);
	localparam logic [CFG_W-1:0] RST_TGT_W = CFG_W'(320);
	localparam logic [CFG_W-1:0] RST_TGT_H = CFG_W'(240);

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [SUM_W-1:0] sum_t;
	typedef logic [DIM_W-1:0] dim_t;
	typedef logic [CFG_W-1:0] cfg_t;

	typedef enum logic [1:0] {
		REG_SRC_W,
		REG_SRC_H,
		REG_TGT_W,
		REG_TGT_H
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HDIV,
		S_VACC,
		S_VDIV,
		S_EMIT
	} state_t;

	function automatic dim_t clamp_dim(input cfg_t v, input dim_t hi);
		dim_t r;
		if (v == '0) begin
			r = dim_t'(1);
		end else if (int'(v) > int'(hi)) begin
			r = hi;
		end else begin
			r = dim_t'(v);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: design/aards_if.sv
// Handshake interfaces for source pixels, result pixels and register writes.
// Depends on aards_pkg.
`default_nettype none

interface aards_pix_if;
	logic valid;
	logic ready;
	aards_pkg::pix_t in_red;
	aards_pkg::pix_t in_green;
	aards_pkg::pix_t in_blue;
	modport source (output valid, in_red, in_green, in_blue, input ready);
	modport sink (input valid, in_red, in_green, in_blue, output ready);
endinterface

interface aards_res_if;
	logic valid;
	logic ready;
	aards_pkg::pix_t out_red;
	aards_pkg::pix_t out_green;
	aards_pkg::pix_t out_blue;
	logic row_end;
	logic frame_end;
	modport source (output valid, out_red, out_green, out_blue, row_end, frame_end,
		input ready);
	modport sink (input valid, out_red, out_green, out_blue, row_end, frame_end,
		output ready);
endinterface

interface aards_cfg_if;
	logic valid;
	logic ready;
	aards_pkg::reg_idx_t index;
	aards_pkg::cfg_t data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: design/area_average_rgb_downscaler.sv
// Area-average RGB downscaler: one source pixel per transfer in raster order. A pixel that
// ends no horizontal span is added to the running horizontal sum. A pixel that ends a
// horizontal span goes through the horizontal divide and the line store read-modify-write,
// and, when it also closes a vertical span, through the vertical divide and the hand-off to
// the output register, plus any wait while that register is still full; one shared
// bit-serial divider does both divides. Results wait in the output register so new input
// is taken while a result is pending. The line store needs no clearing after reset.
// Register writes are taken only between pixels and restart the frame.
`default_nettype none

module area_average_rgb_downscaler (
	input wire logic   clk,
	input wire logic   arst_n,
	aards_pix_if.sink  pix_in,
	aards_res_if.source pix_out,
	aards_cfg_if.sink  cfg
);

	localparam int NCH = aards_pkg::NUM_CH;
	localparam int SW  = aards_pkg::SUM_W;
	localparam int DW  = aards_pkg::DIM_W;
	localparam int CW  = aards_pkg::COL_W;
	localparam int RW  = aards_pkg::ROW_W;

	aards_pkg::cfg_t src_w_q, src_h_q, tgt_w_q, tgt_h_q;
	aards_pkg::dim_t sw, tw, sh, th;

	aards_pkg::sum_t hsum_q [NCH];
	aards_pkg::dim_t hphase_q, vphase_q;
	logic [CW-1:0] scol_q, tcol_q;
	logic [RW-1:0] srow_q, trow_q;

	aards_pkg::state_t state_q, state_d;

	logic [CW-1:0] col_q;
	logic fresh_q, vdone_q, row_end_q, frame_end_q;
	aards_pkg::dim_t vrem_q;
	aards_pkg::pix_t hb_q [NCH];
	aards_pkg::pix_t res_q [NCH];

	logic out_valid_q, out_row_end_q, out_frame_end_q;
	aards_pkg::pix_t out_pix_q [NCH];

	logic in_fire, cfg_fire, emit_ok;
	aards_pkg::dim_t hp, rem, vp, vrem_c;
	logic [CW-1:0] tc;
	logic [RW-1:0] tr;
	logic span_done;
	aards_pkg::pix_t px [NCH];
	aards_pkg::sum_t hdiv [NCH], hcarry [NCH], hacc [NCH];

	aards_pkg::sum_t acc [NCH], vdiv [NCH], vwr [NCH];
	logic [aards_pkg::LINE_W-1:0] ram_rdata, ram_wdata;
	logic ram_we, ram_re;

	logic div_start, div_done;
	aards_pkg::sum_t div_dividend [NCH];
	aards_pkg::dim_t div_divisor;
	aards_pkg::pix_t div_quot [NCH];

	assign sw = aards_pkg::clamp_dim(src_w_q, DW'(aards_pkg::MAX_WIDTH));
	assign tw = aards_pkg::clamp_dim(tgt_w_q, sw);
	assign sh = aards_pkg::clamp_dim(src_h_q, DW'(aards_pkg::MAX_HEIGHT));
	assign th = aards_pkg::clamp_dim(tgt_h_q, sh);

	assign cfg.ready = (state_q == aards_pkg::S_IDLE);
	assign cfg_fire  = cfg.valid && cfg.ready;
	assign pix_in.ready = (state_q == aards_pkg::S_IDLE) && !cfg.valid;
	assign in_fire = pix_in.valid && pix_in.ready;
	assign emit_ok = !out_valid_q || pix_out.ready;

	assign px[0] = pix_in.in_red;
	assign px[1] = pix_in.in_green;
	assign px[2] = pix_in.in_blue;

	always_comb begin
		hp = (hphase_q >= sw) ? '0 : hphase_q;
		vp = (vphase_q >= sh) ? '0 : vphase_q;
		tc = (DW'(tcol_q) >= tw) ? '0 : tcol_q;
		tr = (DW'(trow_q) >= th) ? '0 : trow_q;
		rem = sw - hp;
		vrem_c = sh - vp;
		span_done = !(tw < rem);
		for (int i = 0; i < NCH; i++) begin
			hacc[i]   = hsum_q[i] + SW'(tw) * SW'(px[i]);
			hdiv[i]   = hsum_q[i] + SW'(rem) * SW'(px[i]);
			hcarry[i] = SW'(tw - rem) * SW'(px[i]);
		end
	end

	always_comb begin
		for (int i = 0; i < NCH; i++) begin
			acc[i]  = fresh_q ? '0 : ram_rdata[i*SW +: SW];
			vdiv[i] = acc[i] + SW'(vrem_q) * SW'(hb_q[i]);
			vwr[i]  = vdone_q ? SW'(th - vrem_q) * SW'(hb_q[i])
				: acc[i] + SW'(th) * SW'(hb_q[i]);
			ram_wdata[i*SW +: SW] = vwr[i];
		end
	end

	assign ram_re = in_fire && span_done;
	assign ram_we = (state_q == aards_pkg::S_VACC);

	always_comb begin
		div_start = 1'b0;
		div_divisor = sw;
		for (int i = 0; i < NCH; i++) begin
			div_dividend[i] = hdiv[i];
		end
		if (state_q == aards_pkg::S_VACC) begin
			div_start = vdone_q;
			div_divisor = sh;
			for (int i = 0; i < NCH; i++) begin
				div_dividend[i] = vdiv[i];
			end
		end else if (in_fire && span_done) begin
			div_start = 1'b1;
		end
	end

	aards_ram #(
		.WIDTH(aards_pkg::LINE_W),
		.DEPTH(aards_pkg::MAX_WIDTH)
	) u_line (
		.clk   (clk),
		.we    (ram_we),
		.waddr (col_q),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (tc),
		.rdata (ram_rdata)
	);

	aards_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quot     (div_quot)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			aards_pkg::S_IDLE: begin
				if (in_fire && span_done) begin
					state_d = aards_pkg::S_HDIV;
				end
			end
			aards_pkg::S_HDIV: begin
				if (div_done) begin
					state_d = aards_pkg::S_VACC;
				end
			end
			aards_pkg::S_VACC: begin
				state_d = vdone_q ? aards_pkg::S_VDIV : aards_pkg::S_IDLE;
			end
			aards_pkg::S_VDIV: begin
				if (div_done) begin
					state_d = aards_pkg::S_EMIT;
				end
			end
			aards_pkg::S_EMIT: begin
				if (emit_ok) begin
					state_d = aards_pkg::S_IDLE;
				end
			end
			default: state_d = aards_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aards_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= aards_pkg::RST_SRC_W;
			src_h_q <= aards_pkg::RST_SRC_H;
			tgt_w_q <= aards_pkg::RST_TGT_W;
			tgt_h_q <= aards_pkg::RST_TGT_H;
			for (int i = 0; i < NCH; i++) begin
				hsum_q[i] <= '0;
			end
			hphase_q <= '0;
			vphase_q <= '0;
			scol_q <= '0;
			tcol_q <= '0;
			srow_q <= '0;
			trow_q <= '0;
		end else if (cfg_fire) begin
			unique case (cfg.index)
				aards_pkg::REG_SRC_W: src_w_q <= cfg.data;
				aards_pkg::REG_SRC_H: src_h_q <= cfg.data;
				aards_pkg::REG_TGT_W: tgt_w_q <= cfg.data;
				aards_pkg::REG_TGT_H: tgt_h_q <= cfg.data;
				default: ;
			endcase
			for (int i = 0; i < NCH; i++) begin
				hsum_q[i] <= '0;
			end
			hphase_q <= '0;
			vphase_q <= '0;
			scol_q <= '0;
			tcol_q <= '0;
			srow_q <= '0;
			trow_q <= '0;
		end else if (in_fire) begin
			if (!span_done) begin
				for (int i = 0; i < NCH; i++) begin
					hsum_q[i] <= hacc[i];
				end
				hphase_q <= hp + tw;
			end else begin
				for (int i = 0; i < NCH; i++) begin
					hsum_q[i] <= hcarry[i];
				end
				hphase_q <= tw - rem;
				tcol_q <= (DW'(tc) + DW'(1) >= tw) ? '0 : tc + CW'(1);
			end
			if (DW'(scol_q) + DW'(1) >= sw) begin
				scol_q <= '0;
				hphase_q <= '0;
				tcol_q <= '0;
				for (int i = 0; i < NCH; i++) begin
					hsum_q[i] <= '0;
				end
				if (DW'(srow_q) + DW'(1) >= sh) begin
					srow_q <= '0;
					trow_q <= '0;
					vphase_q <= '0;
				end else begin
					srow_q <= srow_q + RW'(1);
					if (th < vrem_c) begin
						vphase_q <= vp + th;
					end else begin
						vphase_q <= th - vrem_c;
						trow_q <= tr + RW'(1);
					end
				end
			end else begin
				scol_q <= scol_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && span_done) begin
			col_q <= tc;
			fresh_q <= (vp == '0);
			vrem_q <= vrem_c;
			vdone_q <= !(th < vrem_c);
			row_end_q <= (DW'(tc) == tw - DW'(1));
			frame_end_q <= (DW'(tc) == tw - DW'(1)) && (DW'(tr) == th - DW'(1));
		end
		if (state_q == aards_pkg::S_HDIV && div_done) begin
			hb_q <= div_quot;
		end
		if (state_q == aards_pkg::S_VDIV && div_done) begin
			res_q <= div_quot;
		end
		if (state_q == aards_pkg::S_EMIT && emit_ok) begin
			out_pix_q <= res_q;
			out_row_end_q <= row_end_q;
			out_frame_end_q <= frame_end_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == aards_pkg::S_EMIT && emit_ok) begin
			out_valid_q <= 1'b1;
		end else if (pix_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign pix_out.valid     = out_valid_q;
	assign pix_out.out_red   = out_pix_q[0];
	assign pix_out.out_green = out_pix_q[1];
	assign pix_out.out_blue  = out_pix_q[2];
	assign pix_out.row_end   = out_row_end_q;
	assign pix_out.frame_end = out_frame_end_q;

	// The divider only finishes while the control waits for it.
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == aards_pkg::S_HDIV || state_q == aards_pkg::S_VDIV))
		else $error("divider finished outside a divide state");

	a_ram_rw: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("line store read and written in the same cycle");

	a_emit_vdone: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == aards_pkg::S_EMIT) |-> vdone_q)
		else $error("result produced without a closed vertical span");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		(DW'(scol_q) < sw) && (DW'(tcol_q) < tw))
		else $error("column counter out of range");

endmodule

`default_nettype wire

// File: design/aards_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module aards_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: design/aards_div.sv
// Three-lane restoring divider sharing one divisor, one quotient bit per cycle.
// Depends on aards_pkg.
`default_nettype none

module aards_div (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire aards_pkg::sum_t dividend [aards_pkg::NUM_CH],
	input  wire aards_pkg::dim_t divisor,
	output logic                 done,
	output aards_pkg::pix_t      quot [aards_pkg::NUM_CH]
);

	localparam int CNT_W = $clog2(aards_pkg::SUM_W + 1);

	aards_pkg::dim_t rem_q [aards_pkg::NUM_CH];
	aards_pkg::sum_t quo_q [aards_pkg::NUM_CH];
	aards_pkg::dim_t dsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(aards_pkg::SUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		logic [aards_pkg::DIM_W:0] trial;
		logic ge;
		if (start) begin
			dsr_q <= divisor;
			for (int i = 0; i < aards_pkg::NUM_CH; i++) begin
				rem_q[i] <= '0;
				quo_q[i] <= dividend[i];
			end
		end else if (busy_q) begin
			for (int i = 0; i < aards_pkg::NUM_CH; i++) begin
				trial = {rem_q[i], quo_q[i][aards_pkg::SUM_W-1]};
				ge = (trial >= {1'b0, dsr_q});
				rem_q[i] <= ge ? aards_pkg::DIM_W'(trial - {1'b0, dsr_q})
					: aards_pkg::DIM_W'(trial);
				quo_q[i] <= {quo_q[i][aards_pkg::SUM_W-2:0], ge};
			end
		end
	end

	assign done = done_q;

	always_comb begin
		for (int i = 0; i < aards_pkg::NUM_CH; i++) begin
			quot[i] = quo_q[i][aards_pkg::PIX_W-1:0];
		end
	end

endmodule

`default_nettype wire

// File: bench/aards_checker.sv
// Checker for the area-average RGB downscaler: watches the pixel, result and register channels,
// predicts every averaged pixel from its own model of the frame state, and compares.
// Depends on aards_pkg and the channel interfaces.
`timescale 1ns / 100ps

module aards_checker (
	input  logic clk,
	input  logic arst_n,
	aards_pix_if pix_in,
	aards_res_if pix_out,
	aards_cfg_if cfg,
	output int   errors,
	output int   pending
);
	import aards_pkg::*;

	typedef struct {
		pix_t red;
		pix_t green;
		pix_t blue;
		logic row_end;
		logic frame_end;
	} avg_pixel_t;

	avg_pixel_t  expected_pixels[$];
	int unsigned src_w, src_h, tgt_w, tgt_h;
	int unsigned hsum[3];
	int unsigned hphase, src_col, tgt_col;
	int unsigned vsum[MAX_WIDTH][3];
	int unsigned vphase, src_row, tgt_row;

	function automatic int unsigned clamp_size(int unsigned v, int unsigned lo, int unsigned hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	task automatic report(string what, int unsigned got, int unsigned want);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	task automatic restart_frame();
		hsum = '{0, 0, 0};
		hphase = 0;
		src_col = 0;
		tgt_col = 0;
		vphase = 0;
		src_row = 0;
		tgt_row = 0;
	endtask

	task automatic predict_pixel(pix_t r, pix_t g, pix_t b);
		int unsigned sw, tw, sh, th, rem, vrem, acc, col;
		int unsigned px[3], hb[3], res[3];
		bit fresh;
		avg_pixel_t e;
		sw = clamp_size(src_w, 1, MAX_WIDTH);
		tw = clamp_size(tgt_w, 1, sw);
		sh = clamp_size(src_h, 1, MAX_HEIGHT);
		th = clamp_size(tgt_h, 1, sh);
		px = '{r, g, b};
		if (hphase >= sw) hphase = 0;
		if (vphase >= sh) vphase = 0;
		if (tgt_col >= tw) tgt_col = 0;
		if (tgt_row >= th) tgt_row = 0;
		rem = sw - hphase;
		if (tw < rem) begin
			for (int c = 0; c < 3; c++) hsum[c] += tw * px[c];
			hphase += tw;
		end else begin
			col = tgt_col;
			fresh = (vphase == 0);
			for (int c = 0; c < 3; c++) begin
				hb[c] = ((hsum[c] + rem * px[c]) / sw) & 8'hFF;
				hsum[c] = (tw - rem) * px[c];
			end
			hphase = tw - rem;
			vrem = sh - vphase;
			for (int c = 0; c < 3; c++) begin
				acc = fresh ? 0 : vsum[col][c];
				if (th < vrem) begin
					vsum[col][c] = acc + th * hb[c];
				end else begin
					res[c] = ((acc + vrem * hb[c]) / sh) & 8'hFF;
					vsum[col][c] = (th - vrem) * hb[c];
				end
			end
			if (th >= vrem) begin
				e.red = pix_t'(res[0]);
				e.green = pix_t'(res[1]);
				e.blue = pix_t'(res[2]);
				e.row_end = (col == tw - 1);
				e.frame_end = e.row_end && (tgt_row == th - 1);
				expected_pixels.push_back(e);
			end
			tgt_col = col + 1;
			if (tgt_col >= tw) tgt_col = 0;
		end
		src_col++;
		if (src_col >= sw) begin
			src_col = 0;
			hphase = 0;
			tgt_col = 0;
			hsum = '{0, 0, 0};
			vrem = sh - vphase;
			if (th < vrem) begin
				vphase += th;
			end else begin
				vphase = th - vrem;
				tgt_row++;
			end
			src_row++;
			if (src_row >= sh) begin
				src_row = 0;
				tgt_row = 0;
				vphase = 0;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		avg_pixel_t e;
		if (!arst_n) begin
			src_w = RST_SRC_W;
			src_h = RST_SRC_H;
			tgt_w = RST_TGT_W;
			tgt_h = RST_TGT_H;
			restart_frame();
			expected_pixels.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (pix_out.valid && pix_out.ready) begin
				if (expected_pixels.size() == 0) begin
					$display("%0t: result transfer with no pixel expected", $realtime);
					errors++;
				end else begin
					e = expected_pixels.pop_front();
					if (pix_out.out_red !== e.red) report("out_red", pix_out.out_red, e.red);
					if (pix_out.out_green !== e.green)
						report("out_green", pix_out.out_green, e.green);
					if (pix_out.out_blue !== e.blue) report("out_blue", pix_out.out_blue, e.blue);
					if (pix_out.row_end !== e.row_end)
						report("row_end", pix_out.row_end, e.row_end);
					if (pix_out.frame_end !== e.frame_end)
						report("frame_end", pix_out.frame_end, e.frame_end);
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_SRC_W: src_w = cfg.data;
					REG_SRC_H: src_h = cfg.data;
					REG_TGT_W: tgt_w = cfg.data;
					REG_TGT_H: tgt_h = cfg.data;
				endcase
				restart_frame();
			end
			if (pix_in.valid && pix_in.ready)
				predict_pixel(pix_in.in_red, pix_in.in_green, pix_in.in_blue);
			pending = expected_pixels.size();
		end
	end

endmodule

// File: bench/tb_area_average_rgb_downscaler.sv
// Top of the downscaler testbench: clock, reset, register setup, pixel stimulus with
// random idling on both sides, and the verdict. Depends on aards_pkg, the interfaces and aards_checker.
`timescale 1ns / 100ps

module tb_area_average_rgb_downscaler;
	import aards_pkg::*;

	localparam int IDLE_LIMIT = 20000;
	localparam int SETTLE = 120;
	localparam int NUM_SETUPS = 14;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   errors, pending;
	int   idle_pct = 0;
	int   stall_pct = 0;
	int   quiet_cycles = 0;

	aards_pix_if pix();
	aards_res_if res();
	aards_cfg_if cfg();

	area_average_rgb_downscaler dut (
		.clk(clk), .arst_n(arst_n), .pix_in(pix), .pix_out(res), .cfg(cfg)
	);

	aards_checker u_checker (
		.clk(clk), .arst_n(arst_n), .pix_in(pix), .pix_out(res), .cfg(cfg),
		.errors(errors), .pending(pending)
	);

	// Source width, source height, target width, target height, whole frames.
	int unsigned setups[NUM_SETUPS][5] = '{
		'{3, 2, 2, 1, 1},
		'{1, 1, 1, 1, 8},
		'{4, 4, 2, 2, 5},
		'{7, 5, 3, 2, 4},
		'{5, 3, 5, 3, 5},
		'{16, 6, 5, 4, 2},
		'{9, 9, 8, 7, 2},
		'{0, 3, 4095, 0, 20},
		'{6, 10, 1, 10, 2},
		'{300, 2, 299, 1, 1},
		'{0, 0, 0, 0, 0},
		'{0, 0, 0, 0, 0},
		'{0, 0, 0, 0, 0},
		'{0, 0, 0, 0, 0}
	};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else begin
			res.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((pix.valid && pix.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_reg(reg_idx_t idx, cfg_t value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
	endtask

	task automatic send_pixel(pix_t r, pix_t g, pix_t b);
		while ($urandom_range(99) < idle_pct) begin
			pix.valid <= 1'b0;
			@(posedge clk);
		end
		pix.valid <= 1'b1;
		pix.in_red <= r;
		pix.in_green <= g;
		pix.in_blue <= b;
		do @(posedge clk); while (!pix.ready);
	endtask

	function automatic pix_t channel_value(bit directed, int n);
		pix_t pattern[8] = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'hFF, 8'h01, 8'h80, 8'h7F};
		if (directed) return pattern[n % 8];
		case ($urandom_range(9))
			0: return 8'h00;
			1: return 8'hFF;
			default: return pix_t'($urandom_range(255));
		endcase
	endfunction

	task automatic drain();
		pix.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		int unsigned items;
		bit directed;
		pix.valid <= 1'b0;
		pix.in_red <= '0;
		pix.in_green <= '0;
		pix.in_blue <= '0;
		cfg.valid <= 1'b0;
		cfg.index <= REG_SRC_W;
		cfg.data <= '0;
		for (int k = 10; k < NUM_SETUPS; k++) begin
			setups[k][0] = $urandom_range(12, 1);
			setups[k][1] = $urandom_range(8, 1);
			setups[k][2] = $urandom_range(setups[k][0], 1);
			setups[k][3] = $urandom_range(setups[k][1], 1);
			setups[k][4] = 3;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int p = 0; p < NUM_SETUPS; p++) begin
			directed = (p < 2);
			case (p % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 72; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 72; end
				default: begin idle_pct = 26; stall_pct = 26; end
			endcase
			write_reg(REG_SRC_W, cfg_t'(setups[p][0]));
			write_reg(REG_SRC_H, cfg_t'(setups[p][1]));
			write_reg(REG_TGT_W, cfg_t'(setups[p][2]));
			write_reg(REG_TGT_H, cfg_t'(setups[p][3]));
			items = (setups[p][0] == 0 ? 1 : setups[p][0]) * (setups[p][1] == 0 ? 1 : setups[p][1])
				* setups[p][4];
			// A partial frame at the end checks that a register write restarts the frame.
			if (!directed && p % 3 == 0) items += $urandom_range(5, 1);
			for (int n = 0; n < items; n++)
				send_pixel(channel_value(directed, n), channel_value(directed, n + 3),
					channel_value(directed, n + 5));
			drain();
		end
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
